// File: hdl/qoidec_pkg.sv
// Shared types and constants for the QOI image decoder.
// Depends on nothing; used by every module of the decoder.
package qoidec_pkg;

    localparam int INDEX_ENTRIES = 64;
    localparam int INDEX_AW      = $clog2(INDEX_ENTRIES);

    // Header layout: 14 bytes, width in bytes 4..7, height in bytes 8..11
    localparam int         HDR_BYTES   = 14;
    localparam logic [3:0] HDR_LAST    = 4'(HDR_BYTES - 1);
    localparam logic [3:0] HDR_W_FIRST = 4'd4;
    localparam logic [3:0] HDR_W_LAST  = 4'd7;
    localparam logic [3:0] HDR_H_FIRST = 4'd8;
    localparam logic [3:0] HDR_H_LAST  = 4'd11;

    // Op codes and two-bit tags
    localparam logic [7:0] OP_RGB    = 8'hFE;
    localparam logic [7:0] OP_RGBA   = 8'hFF;
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] width_out;
        logic [31:0] height_out;
        logic        run_end;
        logic        image_end;
    } out_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    localparam pixel_t PIXEL_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF};

    // What the decode step of one byte asks the controller to do next
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_HEADER,
        ACT_PIXEL,
        ACT_INDEX
    } action_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic mul;
        logic hdr_emit;
        logic idx_load;
        logic pix_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    out_free;
        logic    run_last;
    } ctrl_sts_t;

endpackage

// File: hdl/qoidec_ctrl.sv
// Sequencing state machine of the QOI decoder.
// Depends on qoidec_pkg; drives commands into qoidec_dpath.
module qoidec_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output qoidec_pkg::ctrl_cmd_t cmd,
    input  qoidec_pkg::ctrl_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_HDR_EMIT,
        ST_IDX_LOAD,
        ST_PIX_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && s_valid && s_ready_reg;
        cmd.decode   = (state_reg == ST_DECODE);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.hdr_emit = (state_reg == ST_HDR_EMIT) && sts.out_free;
        cmd.idx_load = (state_reg == ST_IDX_LOAD);
        cmd.pix_emit = (state_reg == ST_PIX_EMIT) && sts.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.action)
                    qoidec_pkg::ACT_HEADER: state_next = ST_MUL;
                    qoidec_pkg::ACT_PIXEL:  state_next = ST_PIX_EMIT;
                    qoidec_pkg::ACT_INDEX:  state_next = ST_IDX_LOAD;
                    default:                state_next = ST_IDLE;
                endcase
            end
            ST_MUL:      state_next = ST_HDR_EMIT;
            ST_HDR_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDX_LOAD: state_next = ST_PIX_EMIT;
            ST_PIX_EMIT: begin
                if (sts.out_free && sts.run_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

// File: hdl/qoidec_dpath.sv
// Datapath of the QOI decoder: header parse, op decode, color index, output word.
// Depends on qoidec_pkg; steered by qoidec_ctrl.
module qoidec_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qoidec_pkg::ctrl_cmd_t cmd,
    output qoidec_pkg::ctrl_sts_t sts,
    input  qoidec_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output qoidec_pkg::out_word_t m_data
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_LUMA,
        PEND_RGB,
        PEND_RGBA
    } pend_op_t;

    function automatic logic [qoidec_pkg::INDEX_AW-1:0] hash_of(input qoidec_pkg::pixel_t p);
        logic [7:0] sum;
        sum = p.red * 8'd3 + p.green * 8'd5 + p.blue * 8'd7 + p.alpha * 8'd11;
        return sum[qoidec_pkg::INDEX_AW-1:0];
    endfunction

    // Control state
    phase_t             phase_reg,    phase_next;
    logic [3:0]         hcount_reg,   hcount_next;
    logic [31:0]        width_reg,    width_next;
    logic [31:0]        height_reg,   height_next;
    logic [63:0]        pix_left_reg;
    logic [2:0]         pend_cnt_reg, pend_cnt_next;
    pend_op_t           pend_op_reg,  pend_op_next;
    logic [23:0]        partial_reg,  partial_next;
    qoidec_pkg::pixel_t prev_reg;
    logic [qoidec_pkg::INDEX_ENTRIES-1:0] idx_valid_reg;
    logic               m_valid_reg;

    // Payload
    logic [7:0]            byte_reg;
    qoidec_pkg::pixel_t    px_reg,       px_next;
    logic [5:0]            run_left_reg, run_left_next;
    qoidec_pkg::pixel_t    rdata_reg;
    logic                  rvalid_reg;
    qoidec_pkg::out_word_t out_reg;

    qoidec_pkg::pixel_t idx_mem [qoidec_pkg::INDEX_ENTRIES];

    qoidec_pkg::action_t                 action;
    logic                                clear;
    logic                                last_pixel;
    logic [qoidec_pkg::INDEX_AW-1:0]     wr_addr;
    logic [qoidec_pkg::INDEX_AW-1:0]     rd_addr;
    logic [7:0]                          luma_dg;
    logic [7:0]                          luma_dr;
    logic [7:0]                          luma_db;

    assign clear      = cmd.accept && s_data.start_of_file;
    assign last_pixel = (pix_left_reg == 64'd1);
    assign wr_addr    = hash_of(px_reg);
    assign rd_addr    = byte_reg[qoidec_pkg::INDEX_AW-1:0];

    assign luma_dg = {2'b00, partial_reg[5:0]} - 8'd32;
    assign luma_dr = luma_dg + {4'b0000, byte_reg[7:4]} - 8'd8;
    assign luma_db = luma_dg + {4'b0000, byte_reg[3:0]} - 8'd8;

    assign sts.action   = action;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.run_last = (run_left_reg == 6'd0) || last_pixel;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Decode of the held byte against the current parse state
    always_comb begin
        action        = qoidec_pkg::ACT_NONE;
        phase_next    = phase_reg;
        hcount_next   = hcount_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_op_next  = pend_op_reg;
        partial_next  = partial_reg;
        px_next       = px_reg;
        run_left_next = 6'd0;
        case (phase_reg)
            PH_HEADER: begin
                if (hcount_reg inside {[qoidec_pkg::HDR_W_FIRST:qoidec_pkg::HDR_W_LAST]}) begin
                    width_next = {width_reg[23:0], byte_reg};
                end else if (hcount_reg inside
                             {[qoidec_pkg::HDR_H_FIRST:qoidec_pkg::HDR_H_LAST]}) begin
                    height_next = {height_reg[23:0], byte_reg};
                end
                if (hcount_reg == qoidec_pkg::HDR_LAST) begin
                    hcount_next = 4'd0;
                    action      = qoidec_pkg::ACT_HEADER;
                end else begin
                    hcount_next = hcount_reg + 4'd1;
                end
            end
            PH_PIXELS: begin
                if (pend_cnt_reg != 3'd0) begin
                    pend_cnt_next = pend_cnt_reg - 3'd1;
                    if (pend_cnt_next != 3'd0) begin
                        partial_next = {partial_reg[15:0], byte_reg};
                    end else begin
                        case (pend_op_reg)
                            PEND_LUMA: begin
                                px_next.red   = prev_reg.red + luma_dr;
                                px_next.green = prev_reg.green + luma_dg;
                                px_next.blue  = prev_reg.blue + luma_db;
                                px_next.alpha = prev_reg.alpha;
                            end
                            PEND_RGB: begin
                                px_next.red   = partial_reg[15:8];
                                px_next.green = partial_reg[7:0];
                                px_next.blue  = byte_reg;
                                px_next.alpha = prev_reg.alpha;
                            end
                            default: begin
                                px_next.red   = partial_reg[23:16];
                                px_next.green = partial_reg[15:8];
                                px_next.blue  = partial_reg[7:0];
                                px_next.alpha = byte_reg;
                            end
                        endcase
                        pend_op_next = PEND_NONE;
                        partial_next = 24'd0;
                        action       = qoidec_pkg::ACT_PIXEL;
                    end
                end else if (byte_reg == qoidec_pkg::OP_RGB) begin
                    pend_op_next  = PEND_RGB;
                    pend_cnt_next = 3'd3;
                    partial_next  = 24'd0;
                end else if (byte_reg == qoidec_pkg::OP_RGBA) begin
                    pend_op_next  = PEND_RGBA;
                    pend_cnt_next = 3'd4;
                    partial_next  = 24'd0;
                end else begin
                    case (byte_reg[7:6])
                        qoidec_pkg::TAG_INDEX: begin
                            action = qoidec_pkg::ACT_INDEX;
                        end
                        qoidec_pkg::TAG_DIFF: begin
                            px_next.red   = prev_reg.red + {6'd0, byte_reg[5:4]} - 8'd2;
                            px_next.green = prev_reg.green + {6'd0, byte_reg[3:2]} - 8'd2;
                            px_next.blue  = prev_reg.blue + {6'd0, byte_reg[1:0]} - 8'd2;
                            px_next.alpha = prev_reg.alpha;
                            action        = qoidec_pkg::ACT_PIXEL;
                        end
                        qoidec_pkg::TAG_LUMA: begin
                            pend_op_next  = PEND_LUMA;
                            pend_cnt_next = 3'd1;
                            partial_next  = {18'd0, byte_reg[5:0]};
                        end
                        default: begin
                            // run: repeat the previous pixel, count held as length minus one
                            px_next       = prev_reg;
                            run_left_next = byte_reg[5:0];
                            action        = qoidec_pkg::ACT_PIXEL;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Control state, cleared on reset and on a start-of-file word
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            phase_reg     <= PH_HEADER;
            hcount_reg    <= 4'd0;
            width_reg     <= 32'd0;
            height_reg    <= 32'd0;
            pix_left_reg  <= 64'd0;
            pend_cnt_reg  <= 3'd0;
            pend_op_reg   <= PEND_NONE;
            partial_reg   <= 24'd0;
            prev_reg      <= qoidec_pkg::PIXEL_RESET;
            idx_valid_reg <= '0;
        end else begin
            if (cmd.decode) begin
                phase_reg    <= phase_next;
                hcount_reg   <= hcount_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                pend_cnt_reg <= pend_cnt_next;
                pend_op_reg  <= pend_op_next;
                partial_reg  <= partial_next;
            end
            if (cmd.mul) begin
                pix_left_reg <= 64'(width_reg) * 64'(height_reg);
            end
            if (cmd.hdr_emit) begin
                phase_reg <= (pix_left_reg != 64'd0) ? PH_PIXELS : PH_DONE;
            end
            if (cmd.pix_emit) begin
                prev_reg               <= px_reg;
                pix_left_reg           <= pix_left_reg - 64'd1;
                idx_valid_reg[wr_addr] <= 1'b1;
                if (last_pixel) begin
                    phase_reg <= PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.hdr_emit || cmd.pix_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_data.data_byte;
        end
        if (cmd.decode) begin
            px_reg       <= px_next;
            run_left_reg <= run_left_next;
        end
        if (cmd.idx_load) begin
            px_reg       <= rvalid_reg ? rdata_reg : '0;
            run_left_reg <= 6'd0;
        end
        if (cmd.pix_emit) begin
            run_left_reg <= run_left_reg - 6'd1;
        end
        if (cmd.hdr_emit) begin
            out_reg <= '{kind: qoidec_pkg::KIND_HEADER, red: 8'd0, green: 8'd0, blue: 8'd0,
                         alpha: 8'd0, width_out: width_reg, height_out: height_reg,
                         run_end: 1'b1, image_end: 1'b0};
        end else if (cmd.pix_emit) begin
            out_reg <= '{kind: qoidec_pkg::KIND_PIXEL, red: px_reg.red, green: px_reg.green,
                         blue: px_reg.blue, alpha: px_reg.alpha, width_out: 32'd0,
                         height_out: 32'd0, run_end: sts.run_last, image_end: last_pixel};
        end
    end

    // Color index: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.pix_emit) begin
            idx_mem[wr_addr] <= px_reg;
        end
        rdata_reg  <= idx_mem[rd_addr];
        rvalid_reg <= idx_valid_reg[rd_addr];
    end

endmodule

// File: hdl/qoi_image_decoder_core.sv
// QOI image decoder: one file byte per input word, header and pixels out.
// A pixel word is registered after decode (and an index read for INDEX), a header word after the multiply.
// Bytes are taken one at a time: the next byte is held off until the controller sequence
//   has finished the current one, including every pixel of a run.
// Reset (aresetn low, synchronous) clears phase, counters, previous pixel and all 64 index
//   valid bits; a start_of_file word does the same before it is decoded.
module qoi_image_decoder_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  qoidec_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output qoidec_pkg::out_word_t m_data
);

    // Controller and datapath talk only through these two groups
    qoidec_pkg::ctrl_cmd_t cmd;
    qoidec_pkg::ctrl_sts_t sts;

    // Controller: walks each word through decode, header multiply and output, index read
    // and pixel emission; holds off new words until the current one is done.
    qoidec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Datapath: header fields, op decode, previous pixel, 64-entry color
    // index and the output word register that decouples the m_ side.
    qoidec_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hdl/qoidec_checker.sv
// Port-level checks for the QOI decoder top level, attached by bind.
// Depends on qoidec_pkg and qoi_image_decoder_core.
module qoidec_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input qoidec_pkg::in_word_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input qoidec_pkg::out_word_t m_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Drop ready after taking a word: one byte in work at a time
    a_one_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while a byte is in work");

    a_header_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == qoidec_pkg::KIND_HEADER |->
            m_data.run_end && !m_data.image_end)
        else $error("header word without run_end or with image_end");

    a_image_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.image_end |->
            m_data.run_end && m_data.kind == qoidec_pkg::KIND_PIXEL)
        else $error("image_end on a word that does not close its byte");

endmodule

bind qoi_image_decoder_core qoidec_checker u_checker (.*);
